[hdl/rgd_pkg.sv]
// package: shared constants, codes, command and status types, sine table
`default_nettype none
package rgd_pkg;

  localparam int CELL_SHIFT_DEF = 6;
  localparam int ANGLE_BITS_DEF = 12;
  localparam int MAP_BITS_DEF   = 12;

  localparam logic [1:0] ACT_START  = 2'd0;
  localparam logic [1:0] ACT_STEP   = 2'd1;
  localparam logic [1:0] ACT_FINISH = 2'd2;

  localparam logic [1:0] SURF_DOOR = 2'd1;
  localparam logic [1:0] SURF_EXIT = 2'd2;

  localparam logic [2:0] FACE_WEST  = 3'd0;
  localparam logic [2:0] FACE_EAST  = 3'd1;
  localparam logic [2:0] FACE_NORTH = 3'd2;
  localparam logic [2:0] FACE_SOUTH = 3'd3;
  localparam logic [2:0] FACE_DOOR  = 3'd4;
  localparam logic [2:0] FACE_EXIT  = 3'd5;

  localparam int TABLE_DEPTH = 1024;
  localparam int DIV_LAST    = 32;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_CAP_START,
    DP_CAP_FIN,
    DP_ROM_COS,
    DP_ROM_SIN,
    DP_SET_DIR,
    DP_DIV_X,
    DP_DIV_Y,
    DP_MUL_X,
    DP_SIDE_X,
    DP_SIDE_Y,
    DP_STEP,
    DP_OUT_CELL,
    DP_FIN_MUL,
    DP_OUT_FIN
  } dp_op_t;

  typedef struct packed {
    logic div_last;
  } dp_status_t;

  typedef logic [15:0] sine_rom_t [TABLE_DEPTH];

  function automatic sine_rom_t sine_build();
    sine_rom_t t;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] v;
    logic signed [63:0] sum;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      x    = (64'd3373259426 * 64'(i)) >> 11;
      x2   = (x * x) >> 30;
      term = x;
      sum  = $signed(x);
      term = ((term * x2) >> 30) / 64'd6;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd42;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd110;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd156;
      sum  = sum + $signed(term);
      if (sum < 0) begin
        sum = 64'sd0;
      end
      v = ($unsigned(sum) + 64'd8192) >> 14;
      if (v > 64'd65535) begin
        v = 64'd65535;
      end
      t[i] = v[15:0];
    end
    return t;
  endfunction

  localparam sine_rom_t SINE_TABLE = sine_build();

endpackage
`default_nettype wire

[hdl/rgd_ctrl.sv]
// controller: sequencing of start, step and finish words
`default_nettype none
module rgd_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic [1:0]          in_action,
  output logic                     in_stall,
  output logic                     out_valid,
  input  wire logic                out_stall,
  input  wire rgd_pkg::dp_status_t status,
  output rgd_pkg::dp_op_t          op
);

  typedef enum logic [3:0] {
    S_IDLE, S_ROM_C, S_ROM_S, S_DIR, S_DIV_X, S_DIV_Y,
    S_MUL_X, S_SIDE_X, S_SIDE_Y, S_START_OUT, S_FIN_MUL, S_FIN_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   out_free;
  logic   load;

  assign in_stall  = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    op        = rgd_pkg::DP_NOP;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_action)
            rgd_pkg::ACT_START: begin
              op        = rgd_pkg::DP_CAP_START;
              state_nxt = S_ROM_C;
            end
            rgd_pkg::ACT_STEP:   op = rgd_pkg::DP_STEP;
            rgd_pkg::ACT_FINISH: begin
              op        = rgd_pkg::DP_CAP_FIN;
              state_nxt = S_FIN_MUL;
            end
            default: op = rgd_pkg::DP_OUT_CELL;
          endcase
        end
      end
      S_ROM_C: begin
        op        = rgd_pkg::DP_ROM_COS;
        state_nxt = S_ROM_S;
      end
      S_ROM_S: begin
        op        = rgd_pkg::DP_ROM_SIN;
        state_nxt = S_DIR;
      end
      S_DIR: begin
        op        = rgd_pkg::DP_SET_DIR;
        state_nxt = S_DIV_X;
      end
      S_DIV_X: begin
        op = rgd_pkg::DP_DIV_X;
        if (status.div_last) begin
          state_nxt = S_DIV_Y;
        end
      end
      S_DIV_Y: begin
        op = rgd_pkg::DP_DIV_Y;
        if (status.div_last) begin
          state_nxt = S_MUL_X;
        end
      end
      S_MUL_X: begin
        op        = rgd_pkg::DP_MUL_X;
        state_nxt = S_SIDE_X;
      end
      S_SIDE_X: begin
        op        = rgd_pkg::DP_SIDE_X;
        state_nxt = S_SIDE_Y;
      end
      S_SIDE_Y: begin
        op        = rgd_pkg::DP_SIDE_Y;
        state_nxt = S_START_OUT;
      end
      S_START_OUT: begin
        if (out_free) begin
          op        = rgd_pkg::DP_OUT_CELL;
          state_nxt = S_IDLE;
        end
      end
      S_FIN_MUL: begin
        op        = rgd_pkg::DP_FIN_MUL;
        state_nxt = S_FIN_OUT;
      end
      S_FIN_OUT: begin
        if (out_free) begin
          op        = rgd_pkg::DP_OUT_FIN;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign load = (op == rgd_pkg::DP_STEP) || (op == rgd_pkg::DP_OUT_CELL) ||
                (op == rgd_pkg::DP_OUT_FIN);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

[hdl/rgd_datapath.sv]
// datapath: ray state, sine rom, serial reciprocal, shared multiplier, result word
`default_nettype none
module rgd_datapath #(
  parameter int CELL_SHIFT = rgd_pkg::CELL_SHIFT_DEF,
  parameter int ANGLE_BITS = rgd_pkg::ANGLE_BITS_DEF,
  parameter int MAP_BITS   = rgd_pkg::MAP_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire rgd_pkg::dp_op_t       op,
  output rgd_pkg::dp_status_t        status,
  input  wire logic [ANGLE_BITS-1:0] in_ray_angle,
  input  wire logic [23:0]           in_player_x,
  input  wire logic [23:0]           in_player_y,
  input  wire logic [1:0]            in_special_surface,
  output logic signed [11:0]         out_map_x,
  output logic signed [11:0]         out_map_y,
  output logic                       out_side_crossed,
  output logic [31:0]                out_ray_distance,
  output logic [15:0]                out_wall_fraction,
  output logic [2:0]                 out_face
);

  localparam int FRAC      = 8 + CELL_SHIFT;
  localparam int FRAC_SHL  = (FRAC <= 16) ? 16 - FRAC : 0;
  localparam int FRAC_SHR  = (FRAC > 16) ? FRAC - 16 : 0;
  localparam logic [31:0] FRAC_MASK = 32'((64'd1 << FRAC) - 64'd1);
  localparam logic [31:0] MAP_MAX_U = 32'((64'd1 << (MAP_BITS - 1)) - 64'd1);
  localparam logic signed [MAP_BITS-1:0] MAP_MAX = MAP_MAX_U[MAP_BITS-1:0];
  localparam logic signed [MAP_BITS-1:0] MAP_MIN = ~MAP_MAX;

  function automatic logic [15:0] frac16(input logic [23:0] p);
    logic [31:0] f;
    f = {8'd0, p} & FRAC_MASK;
    return (FRAC <= 16) ? 16'(f << FRAC_SHL) : 16'(f >> FRAC_SHR);
  endfunction

  function automatic logic signed [MAP_BITS-1:0] cell_of(input logic [23:0] p);
    logic [31:0] c;
    c = 32'(p >> FRAC);
    return (c > MAP_MAX_U) ? MAP_MAX : MAP_BITS'(c);
  endfunction

  function automatic logic [15:0] mag16(input logic signed [16:0] d);
    return d[16] ? 16'(-d) : d[15:0];
  endfunction

  function automatic logic [31:0] sat33(input logic [32:0] v);
    return v[32] ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic logic signed [MAP_BITS-1:0] step_cell(
    input logic signed [MAP_BITS-1:0] c, input logic neg);
    if (neg) begin
      return (c != MAP_MIN) ? c - 1'b1 : MAP_MIN;
    end
    return (c != MAP_MAX) ? c + 1'b1 : MAP_MAX;
  endfunction

  function automatic logic [11:0] map12(input logic signed [MAP_BITS-1:0] c);
    logic signed [31:0] e;
    e = 32'(c);
    return e[11:0];
  endfunction

  // architectural ray state
  logic signed [16:0]         dir_cos_r, dir_cos_nxt, dir_sin_r, dir_sin_nxt;
  logic [23:0]                cell_pos_x_r, cell_pos_x_nxt, cell_pos_y_r, cell_pos_y_nxt;
  logic signed [MAP_BITS-1:0] cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic [31:0]                delta_x_r, delta_x_nxt, delta_y_r, delta_y_nxt;
  logic [31:0]                sdx_r, sdx_nxt, sdy_r, sdy_nxt;
  logic                       neg_x_r, neg_x_nxt, neg_y_r, neg_y_nxt;
  logic                       last_side_r, last_side_nxt;

  // working registers
  logic [ANGLE_BITS-1:0] ang_r, ang_nxt;
  logic [1:0]            sp_r, sp_nxt;
  logic [15:0]           rom_q_r, rom_q_nxt, cm_r, cm_nxt;
  logic                  rom_sat_r, rom_sat_nxt;
  logic [15:0]           den_r, den_nxt, rem_r, rem_nxt;
  logic [32:0]           quo_r, quo_nxt;
  logic [5:0]            cnt_r, cnt_nxt;
  logic [48:0]           prod_r, prod_nxt;
  logic [31:0]           dist_r, dist_nxt;
  logic [15:0]           base_r, base_nxt;
  logic                  fneg_r, fneg_nxt;
  logic [2:0]            face_r, face_nxt;

  // result word
  logic [11:0] omx_r, omx_nxt, omy_r, omy_nxt;
  logic        oside_r, oside_nxt;
  logic [31:0] odist_r, odist_nxt;
  logic [15:0] owall_r, owall_nxt;
  logic [2:0]  oface_r, oface_nxt;

  logic [1:0]       quad;
  logic [9:0]       r10;
  logic [10:0]      cos_idx, sin_idx, rom_idx;
  logic [15:0]      rom_val;
  logic signed [16:0] dc, ds;
  logic [16:0]      div_sh;
  logic             div_ge;
  logic [15:0]      div_rem;
  logic [32:0]      div_quo;
  logic             div_last;
  logic [16:0]      dx_d, dy_d;
  logic [31:0]      fin_dist;
  logic [48:0]      wall_p;

  assign quad = ang_r[ANGLE_BITS-1 -: 2];
  if (ANGLE_BITS >= 12) begin : g_ang_shr
    assign r10 = 10'(ang_r[ANGLE_BITS-3:0] >> (ANGLE_BITS - 12));
  end else begin : g_ang_shl
    assign r10 = {ang_r[ANGLE_BITS-3:0], {(12 - ANGLE_BITS){1'b0}}};
  end

  assign cos_idx = quad[0] ? {1'b0, r10} : 11'd1024 - {1'b0, r10};
  assign sin_idx = quad[0] ? 11'd1024 - {1'b0, r10} : {1'b0, r10};
  assign rom_idx = (op == rgd_pkg::DP_ROM_SIN) ? sin_idx : cos_idx;
  assign rom_val = rom_sat_r ? 16'hFFFF : rom_q_r;

  assign dc = (quad == 2'd1 || quad == 2'd2) ? -$signed({1'b0, cm_r}) : $signed({1'b0, cm_r});
  assign ds = quad[1] ? -$signed({1'b0, rom_val}) : $signed({1'b0, rom_val});

  assign div_sh   = {rem_r, (cnt_r == 6'd0)};
  assign div_ge   = div_sh >= {1'b0, den_r};
  assign div_rem  = div_ge ? 16'(div_sh - {1'b0, den_r}) : div_sh[15:0];
  assign div_quo  = {quo_r[31:0], div_ge};
  assign div_last = cnt_r == 6'(rgd_pkg::DIV_LAST);
  assign status.div_last = div_last;

  assign dx_d = neg_x_r ? {1'b0, frac16(cell_pos_x_r)} : 17'h10000 - {1'b0, frac16(cell_pos_x_r)};
  assign dy_d = neg_y_r ? {1'b0, frac16(cell_pos_y_r)} : 17'h10000 - {1'b0, frac16(cell_pos_y_r)};

  assign fin_dist = last_side_r ? ((sdy_r >= delta_y_r) ? sdy_r - delta_y_r : 32'd0)
                                : ((sdx_r >= delta_x_r) ? sdx_r - delta_x_r : 32'd0);
  assign wall_p = fneg_r ? 49'(-prod_r) : prod_r;

  always_comb begin
    dir_cos_nxt = dir_cos_r;       dir_sin_nxt = dir_sin_r;
    cell_pos_x_nxt = cell_pos_x_r; cell_pos_y_nxt = cell_pos_y_r;
    cur_x_nxt = cur_x_r;           cur_y_nxt = cur_y_r;
    delta_x_nxt = delta_x_r;       delta_y_nxt = delta_y_r;
    sdx_nxt = sdx_r;               sdy_nxt = sdy_r;
    neg_x_nxt = neg_x_r;           neg_y_nxt = neg_y_r;
    last_side_nxt = last_side_r;
    ang_nxt = ang_r;   sp_nxt = sp_r;
    rom_q_nxt = rom_q_r; rom_sat_nxt = rom_sat_r; cm_nxt = cm_r;
    den_nxt = den_r;   rem_nxt = rem_r; quo_nxt = quo_r; cnt_nxt = cnt_r;
    prod_nxt = prod_r; dist_nxt = dist_r; base_nxt = base_r;
    fneg_nxt = fneg_r; face_nxt = face_r;
    omx_nxt = omx_r;   omy_nxt = omy_r; oside_nxt = oside_r;
    odist_nxt = odist_r; owall_nxt = owall_r; oface_nxt = oface_r;
    case (op)
      rgd_pkg::DP_CAP_START: begin
        ang_nxt        = in_ray_angle;
        cell_pos_x_nxt = in_player_x;
        cell_pos_y_nxt = in_player_y;
      end
      rgd_pkg::DP_CAP_FIN: sp_nxt = in_special_surface;
      rgd_pkg::DP_ROM_COS, rgd_pkg::DP_ROM_SIN: begin
        rom_q_nxt   = rgd_pkg::SINE_TABLE[rom_idx[9:0]];
        rom_sat_nxt = rom_idx[10];
        cm_nxt      = rom_val;
      end
      rgd_pkg::DP_SET_DIR: begin
        dir_cos_nxt   = dc;
        dir_sin_nxt   = ds;
        neg_x_nxt     = dc[16];
        neg_y_nxt     = ds[16];
        cur_x_nxt     = cell_of(cell_pos_x_r);
        cur_y_nxt     = cell_of(cell_pos_y_r);
        last_side_nxt = 1'b0;
        den_nxt       = cm_r;
        rem_nxt       = 16'd0;
        quo_nxt       = 33'd0;
        cnt_nxt       = 6'd0;
      end
      rgd_pkg::DP_DIV_X, rgd_pkg::DP_DIV_Y: begin
        rem_nxt = div_rem;
        quo_nxt = div_quo;
        cnt_nxt = cnt_r + 6'd1;
        if (div_last) begin
          if (op == rgd_pkg::DP_DIV_X) begin
            delta_x_nxt = sat33(div_quo);
          end else begin
            delta_y_nxt = sat33(div_quo);
          end
          den_nxt = mag16(dir_sin_r);
          rem_nxt = 16'd0;
          quo_nxt = 33'd0;
          cnt_nxt = 6'd0;
        end
      end
      rgd_pkg::DP_MUL_X: prod_nxt = 49'(dx_d * delta_x_r);
      rgd_pkg::DP_SIDE_X: begin
        sdx_nxt  = sat33(prod_r[48:16]);
        prod_nxt = 49'(dy_d * delta_y_r);
      end
      rgd_pkg::DP_SIDE_Y: sdy_nxt = sat33(prod_r[48:16]);
      rgd_pkg::DP_STEP: begin
        if (sdx_r < sdy_r) begin
          sdx_nxt       = sat33({1'b0, sdx_r} + {1'b0, delta_x_r});
          cur_x_nxt     = step_cell(cur_x_r, neg_x_r);
          last_side_nxt = 1'b0;
        end else begin
          sdy_nxt       = sat33({1'b0, sdy_r} + {1'b0, delta_y_r});
          cur_y_nxt     = step_cell(cur_y_r, neg_y_r);
          last_side_nxt = 1'b1;
        end
        omx_nxt   = map12(cur_x_nxt);
        omy_nxt   = map12(cur_y_nxt);
        oside_nxt = last_side_nxt;
        odist_nxt = 32'd0;
        owall_nxt = 16'd0;
        oface_nxt = rgd_pkg::FACE_WEST;
      end
      rgd_pkg::DP_OUT_CELL: begin
        omx_nxt   = map12(cur_x_r);
        omy_nxt   = map12(cur_y_r);
        oside_nxt = last_side_r;
        odist_nxt = 32'd0;
        owall_nxt = 16'd0;
        oface_nxt = rgd_pkg::FACE_WEST;
      end
      rgd_pkg::DP_FIN_MUL: begin
        dist_nxt = fin_dist;
        if (last_side_r) begin
          prod_nxt = 49'(fin_dist * mag16(dir_cos_r));
          fneg_nxt = dir_cos_r[16];
          base_nxt = frac16(cell_pos_x_r);
          face_nxt = neg_y_r ? rgd_pkg::FACE_SOUTH : rgd_pkg::FACE_NORTH;
        end else begin
          prod_nxt = 49'(fin_dist * mag16(dir_sin_r));
          fneg_nxt = dir_sin_r[16];
          base_nxt = frac16(cell_pos_y_r);
          face_nxt = neg_x_r ? rgd_pkg::FACE_EAST : rgd_pkg::FACE_WEST;
        end
        if (sp_r == rgd_pkg::SURF_DOOR) begin
          face_nxt = rgd_pkg::FACE_DOOR;
        end else if (sp_r == rgd_pkg::SURF_EXIT) begin
          face_nxt = rgd_pkg::FACE_EXIT;
        end
      end
      rgd_pkg::DP_OUT_FIN: begin
        omx_nxt   = map12(cur_x_r);
        omy_nxt   = map12(cur_y_r);
        oside_nxt = last_side_r;
        odist_nxt = dist_r;
        owall_nxt = base_r + wall_p[31:16];
        oface_nxt = face_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_cos_r <= '0;    dir_sin_r <= '0;
      cell_pos_x_r <= '0; cell_pos_y_r <= '0;
      cur_x_r <= '0;      cur_y_r <= '0;
      delta_x_r <= '0;    delta_y_r <= '0;
      sdx_r <= '0;        sdy_r <= '0;
      neg_x_r <= 1'b0;    neg_y_r <= 1'b0;
      last_side_r <= 1'b0;
    end else begin
      dir_cos_r <= dir_cos_nxt;       dir_sin_r <= dir_sin_nxt;
      cell_pos_x_r <= cell_pos_x_nxt; cell_pos_y_r <= cell_pos_y_nxt;
      cur_x_r <= cur_x_nxt;           cur_y_r <= cur_y_nxt;
      delta_x_r <= delta_x_nxt;       delta_y_r <= delta_y_nxt;
      sdx_r <= sdx_nxt;               sdy_r <= sdy_nxt;
      neg_x_r <= neg_x_nxt;           neg_y_r <= neg_y_nxt;
      last_side_r <= last_side_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ang_r <= ang_nxt;     sp_r <= sp_nxt;
    rom_q_r <= rom_q_nxt; rom_sat_r <= rom_sat_nxt; cm_r <= cm_nxt;
    den_r <= den_nxt;     rem_r <= rem_nxt; quo_r <= quo_nxt; cnt_r <= cnt_nxt;
    prod_r <= prod_nxt;   dist_r <= dist_nxt; base_r <= base_nxt;
    fneg_r <= fneg_nxt;   face_r <= face_nxt;
    omx_r <= omx_nxt;     omy_r <= omy_nxt; oside_r <= oside_nxt;
    odist_r <= odist_nxt; owall_r <= owall_nxt; oface_r <= oface_nxt;
  end

  assign out_map_x         = $signed(omx_r);
  assign out_map_y         = $signed(omy_r);
  assign out_side_crossed  = oside_r;
  assign out_ray_distance  = odist_r;
  assign out_wall_fraction = owall_r;
  assign out_face          = oface_r;

endmodule
`default_nettype wire

[hdl/ray_grid_dda_traversal.sv]
// top level: dda grid ray traversal, controller plus datapath
//
// input channel (in_valid/in_stall) takes one word per action: start,
// step or finish. every accepted word yields exactly one result word on
// the out_valid/out_stall channel, which is held in an output register
// and stays unchanged while out_stall is high.
// step words and unknown action codes give their result the cycle after
// acceptance; a new word can come every cycle while out_stall is low.
// start runs two reads of the sine rom, then two serial reciprocal
// divisions, then two passes through the shared 17x32 multiplier for
// the first side distances.
// finish runs one multiply for the wall hit position.
// while a start or finish is in work, in_stall is high; it is also high
// while a result waits and out_stall is high.
// reset clears the ray state to zero and empties the output register.
`default_nettype none
module ray_grid_dda_traversal #(
  parameter int CELL_SHIFT = rgd_pkg::CELL_SHIFT_DEF,
  parameter int ANGLE_BITS = rgd_pkg::ANGLE_BITS_DEF,
  parameter int MAP_BITS   = rgd_pkg::MAP_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [1:0]            in_action,
  input  wire logic [ANGLE_BITS-1:0] in_ray_angle,
  input  wire logic [23:0]           in_player_x,
  input  wire logic [23:0]           in_player_y,
  input  wire logic [1:0]            in_special_surface,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic signed [11:0]         out_map_x,
  output logic signed [11:0]         out_map_y,
  output logic                       out_side_crossed,
  output logic [31:0]                out_ray_distance,
  output logic [15:0]                out_wall_fraction,
  output logic [2:0]                 out_face
);

  rgd_pkg::dp_op_t     op;
  rgd_pkg::dp_status_t status;

  rgd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .op        (op)
  );

  rgd_datapath #(
    .CELL_SHIFT (CELL_SHIFT),
    .ANGLE_BITS (ANGLE_BITS),
    .MAP_BITS   (MAP_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .op                 (op),
    .status             (status),
    .in_ray_angle       (in_ray_angle),
    .in_player_x        (in_player_x),
    .in_player_y        (in_player_y),
    .in_special_surface (in_special_surface),
    .out_map_x          (out_map_x),
    .out_map_y          (out_map_y),
    .out_side_crossed   (out_side_crossed),
    .out_ray_distance   (out_ray_distance),
    .out_wall_fraction  (out_wall_fraction),
    .out_face           (out_face)
  );

`ifndef SYNTHESIS
  a_step_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_action == rgd_pkg::ACT_STEP |=> out_valid)
    else $error("step word gave no result");

  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while result blocked");

  a_face_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_face <= rgd_pkg::FACE_EXIT)
    else $error("face code out of range");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_action == rgd_pkg::ACT_START |=> in_stall)
    else $error("start word did not occupy the block");
`endif

endmodule
`default_nettype wire

[bench/ray_grid_dda_traversal_tb.sv]
// testbench: ray_grid_dda_traversal checked against a bit-exact dda predictor
`default_nettype none
module ray_grid_dda_traversal_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC_BITS = 8 + rgd_pkg::CELL_SHIFT_DEF;
  localparam int MAP_MAX = 2047;
  localparam int MAP_MIN = -2048;

  typedef struct {
    logic [1:0]  action;
    logic [11:0] angle;
    logic [23:0] px;
    logic [23:0] py;
    logic [1:0]  surf;
  } ray_word_t;

  typedef struct {
    logic signed [11:0] mx;
    logic signed [11:0] my;
    logic               side;
    logic [31:0]        ray_dist;
    logic [15:0]        wall;
    logic [2:0]         face;
  } cell_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_action = '0;
  logic [11:0] in_ray_angle = '0;
  logic [23:0] in_player_x = '0;
  logic [23:0] in_player_y = '0;
  logic [1:0] in_special_surface = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [11:0] out_map_x;
  logic signed [11:0] out_map_y;
  logic out_side_crossed;
  logic [31:0] out_ray_distance;
  logic [15:0] out_wall_fraction;
  logic [2:0] out_face;

  ray_grid_dda_traversal dut (.*);

  ray_word_t  pending_words[$];
  cell_word_t expected_cells[$];
  int  fail_count = 0;
  bit  feed_done = 1'b0;
  bit  calm = 1'b0;
  int  hold_off = 0;
  bit  hold_done = 1'b0;
  int  accepted = 0;
  int  send_gap = 0;
  int  recv_gap = 0;
  logic in_stall_q = 1'b1;

  logic [15:0] sine_q[1024];
  logic signed [31:0] dir_cos, dir_sin, cell_x, cell_y;
  logic [31:0] pos_x, pos_y, delta_x, delta_y, side_x, side_y;
  logic neg_x, neg_y, last_side;

  initial forever #5 clk = ~clk;

  initial begin
    #50_000_000;
    $display("** ray_grid_dda_traversal: FAILED **");
    $finish;
  end

  function automatic void fill_sine();
    logic [63:0] x, x2, term, v;
    longint sum;
    for (int i = 0; i < 1024; i++) begin
      x = (64'd3373259426 * 64'(i)) / 2048;
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      for (int k = 1; k <= 6; k++) begin
        term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) sum -= longint'(term);
        else sum += longint'(term);
      end
      if (sum < 0) sum = 0;
      v = (64'(sum) + 64'd8192) >> 14;
      if (v > 64'd65535) v = 64'd65535;
      sine_q[i] = v[15:0];
    end
  endfunction

  function automatic logic signed [31:0] qsin(int k);
    if (k >= 1024) return 32'sd65535;
    return {16'd0, sine_q[k]};
  endfunction

  function automatic logic [31:0] inverse_of(logic signed [31:0] d);
    logic [63:0] m, v;
    m = d < 0 ? 64'(-d) : 64'(d);
    if (m == 0) return 32'hFFFF_FFFF;
    v = (64'd1 << 32) / m;
    return v > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic logic [31:0] pos_frac16(logic [31:0] p);
    logic [31:0] f;
    f = p & ((32'd1 << FRAC_BITS) - 1);
    return FRAC_BITS <= 16 ? f << (16 - FRAC_BITS) : f >> (FRAC_BITS - 16);
  endfunction

  function automatic logic signed [31:0] cell_from(logic [31:0] p);
    logic [31:0] c;
    c = p >> FRAC_BITS;
    return c > MAP_MAX ? MAP_MAX : $signed(c);
  endfunction

  function automatic logic [31:0] first_line(logic [31:0] p, logic n, logic [31:0] dl);
    logic [63:0] d, v;
    d = n ? 64'(pos_frac16(p)) : 64'd65536 - 64'(pos_frac16(p));
    v = (d * 64'(dl)) >> 16;
    return v > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
    logic [32:0] v;
    v = {1'b0, a} + {1'b0, b};
    return v[32] ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic logic signed [31:0] next_cell(logic signed [31:0] c, logic n);
    if (n) return c > MAP_MIN ? c - 1 : MAP_MIN;
    return c < MAP_MAX ? c + 1 : MAP_MAX;
  endfunction

  function automatic logic [15:0] hit_frac(logic [31:0] base, logic [31:0] span,
                                           logic signed [31:0] d);
    logic [63:0] mag, p;
    mag = d < 0 ? 64'(-d) : 64'(d);
    p = 64'(span) * mag;
    if (d < 0) p = 64'd0 - p;
    return 16'(64'(base) + (p >> 16));
  endfunction

  function automatic cell_word_t trace_word(ray_word_t w);
    cell_word_t r;
    int q, k;
    logic signed [31:0] cm, sm;
    r.ray_dist = '0;
    r.wall = '0;
    r.face = rgd_pkg::FACE_WEST;
    if (w.action == rgd_pkg::ACT_START) begin
      q = w.angle[11:10];
      k = w.angle[9:0];
      if (q % 2 == 1) begin
        cm = qsin(k);
        sm = qsin(1024 - k);
      end else begin
        cm = qsin(1024 - k);
        sm = qsin(k);
      end
      dir_cos = (q == 1 || q == 2) ? -cm : cm;
      dir_sin = q >= 2 ? -sm : sm;
      pos_x = {8'd0, w.px};
      pos_y = {8'd0, w.py};
      cell_x = cell_from(pos_x);
      cell_y = cell_from(pos_y);
      delta_x = inverse_of(dir_cos);
      delta_y = inverse_of(dir_sin);
      neg_x = dir_cos < 0;
      neg_y = dir_sin < 0;
      side_x = first_line(pos_x, neg_x, delta_x);
      side_y = first_line(pos_y, neg_y, delta_y);
      last_side = 1'b0;
    end else if (w.action == rgd_pkg::ACT_STEP) begin
      if (side_x < side_y) begin
        side_x = add_sat(side_x, delta_x);
        cell_x = next_cell(cell_x, neg_x);
        last_side = 1'b0;
      end else begin
        side_y = add_sat(side_y, delta_y);
        cell_y = next_cell(cell_y, neg_y);
        last_side = 1'b1;
      end
    end else if (w.action == rgd_pkg::ACT_FINISH) begin
      if (!last_side) begin
        r.ray_dist = side_x >= delta_x ? side_x - delta_x : '0;
        r.wall = hit_frac(pos_frac16(pos_y), r.ray_dist, dir_sin);
        r.face = neg_x ? rgd_pkg::FACE_EAST : rgd_pkg::FACE_WEST;
      end else begin
        r.ray_dist = side_y >= delta_y ? side_y - delta_y : '0;
        r.wall = hit_frac(pos_frac16(pos_x), r.ray_dist, dir_cos);
        r.face = neg_y ? rgd_pkg::FACE_SOUTH : rgd_pkg::FACE_NORTH;
      end
      if (w.surf == rgd_pkg::SURF_DOOR) r.face = rgd_pkg::FACE_DOOR;
      else if (w.surf == rgd_pkg::SURF_EXIT) r.face = rgd_pkg::FACE_EXIT;
    end
    r.mx = cell_x[11:0];
    r.my = cell_y[11:0];
    r.side = last_side;
    return r;
  endfunction

  function automatic ray_word_t make_word(logic [1:0] a, logic [11:0] ang, logic [23:0] x,
                                          logic [23:0] y, logic [1:0] s);
    ray_word_t w;
    w.action = a;
    w.angle = ang;
    w.px = x;
    w.py = y;
    w.surf = s;
    return w;
  endfunction

  function automatic ray_word_t rand_word(logic [1:0] a);
    return make_word(a, 12'($urandom), 24'($urandom), 24'($urandom), 2'($urandom));
  endfunction

  // sender
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || !in_stall_q) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          in_valid <= 1'b1;
          in_action <= pending_words[0].action;
          in_ray_angle <= pending_words[0].angle;
          in_player_x <= pending_words[0].px;
          in_player_y <= pending_words[0].py;
          in_special_surface <= pending_words[0].surf;
          void'(pending_words.pop_front());
          if (!calm && $urandom_range(0, 7) == 0) send_gap <= $urandom_range(1, 10);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (in_valid && !in_stall) begin
      expected_cells.push_back(trace_word(make_word(in_action, in_ray_angle, in_player_x,
                                                    in_player_y, in_special_surface)));
      accepted <= accepted + 1;
    end
    in_stall_q <= in_valid && in_stall;
  end

  // receiver stall
  always @(negedge clk) begin
    if (rst_n) begin
      if (!hold_done && accepted > 300) begin
        if (hold_off < 400) begin
          hold_off <= hold_off + 1;
          out_stall <= 1'b1;
        end else begin
          hold_done <= 1'b1;
          out_stall <= 1'b0;
        end
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (!calm && $urandom_range(0, 7) == 0) recv_gap <= $urandom_range(1, 10);
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    cell_word_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_cells.size() == 0) begin
        $error("result word with nothing expected");
        fail_count++;
      end else begin
        e = expected_cells.pop_front();
        if (out_map_x !== e.mx) begin
          $error("map_x expected %0d got %0d", e.mx, out_map_x); fail_count++;
        end
        if (out_map_y !== e.my) begin
          $error("map_y expected %0d got %0d", e.my, out_map_y); fail_count++;
        end
        if (out_side_crossed !== e.side) begin
          $error("side_crossed expected %0d got %0d", e.side, out_side_crossed);
          fail_count++;
        end
        if (out_ray_distance !== e.ray_dist) begin
          $error("ray_distance expected %h got %h", e.ray_dist, out_ray_distance);
          fail_count++;
        end
        if (out_wall_fraction !== e.wall) begin
          $error("wall_fraction expected %h got %h", e.wall, out_wall_fraction);
          fail_count++;
        end
        if (out_face !== e.face) begin
          $error("face expected %0d got %0d", e.face, out_face); fail_count++;
        end
      end
    end
  end

  initial begin
    int steps;
    int total;
    fill_sine();
    dir_cos = 0; dir_sin = 0; cell_x = 0; cell_y = 0;
    pos_x = 0; pos_y = 0; delta_x = 0; delta_y = 0; side_x = 0; side_y = 0;
    neg_x = 0; neg_y = 0; last_side = 0;
    // directed: finish before start, axis angles, extremes, surfaces, unknown action
    pending_words.push_back(make_word(rgd_pkg::ACT_FINISH, '0, '0, '0, 2'd0));
    pending_words.push_back(make_word(2'd3, '1, '1, '1, 2'd3));
    pending_words.push_back(make_word(rgd_pkg::ACT_START, 12'd0, '0, '0, 2'd0));
    pending_words.push_back(make_word(rgd_pkg::ACT_FINISH, '0, '0, '0, 2'd0));
    pending_words.push_back(make_word(rgd_pkg::ACT_STEP, '0, '0, '0, 2'd0));
    pending_words.push_back(make_word(rgd_pkg::ACT_STEP, '0, '0, '0, 2'd0));
    pending_words.push_back(make_word(rgd_pkg::ACT_FINISH, '0, '0, '0, 2'd3));
    pending_words.push_back(make_word(rgd_pkg::ACT_START, 12'd1024, '1, '1, 2'd0));
    pending_words.push_back(make_word(rgd_pkg::ACT_STEP, '0, '0, '0, 2'd0));
    pending_words.push_back(make_word(rgd_pkg::ACT_FINISH, '0, '0, '0, rgd_pkg::SURF_DOOR));
    pending_words.push_back(make_word(rgd_pkg::ACT_START, 12'd2048, 24'h000100, '1, 2'd0));
    pending_words.push_back(make_word(rgd_pkg::ACT_STEP, '0, '0, '0, 2'd0));
    pending_words.push_back(make_word(rgd_pkg::ACT_STEP, '0, '0, '0, 2'd0));
    pending_words.push_back(make_word(rgd_pkg::ACT_FINISH, '0, '0, '0, rgd_pkg::SURF_EXIT));
    pending_words.push_back(make_word(rgd_pkg::ACT_START, 12'd3072, '0, 24'h3FFF, 2'd0));
    pending_words.push_back(make_word(rgd_pkg::ACT_STEP, '0, '0, '0, 2'd0));
    pending_words.push_back(make_word(rgd_pkg::ACT_FINISH, '0, '0, '0, 2'd0));
    pending_words.push_back(make_word(rgd_pkg::ACT_START, 12'd4095, 24'h5555AA, 24'hAAAA55,
                                      2'd0));
    pending_words.push_back(make_word(rgd_pkg::ACT_STEP, '0, '0, '0, 2'd0));
    pending_words.push_back(make_word(rgd_pkg::ACT_FINISH, '0, '0, '0, 2'd0));
    pending_words.push_back(make_word(rgd_pkg::ACT_START, 12'd512, 24'hFFFFFF, 24'd0, 2'd0));
    pending_words.push_back(make_word(rgd_pkg::ACT_FINISH, '0, '0, '0, 2'd0));
    // random rays: mostly start, a run of steps, finish; some noise
    total = 0;
    while (total < 1600) begin
      if ($urandom_range(0, 9) == 0) begin
        pending_words.push_back(rand_word(2'($urandom)));
        total++;
      end else begin
        ray_word_t s;
        s = rand_word(rgd_pkg::ACT_START);
        if ($urandom_range(0, 3) == 0) s.px = 24'($urandom_range(0, 4095));
        if ($urandom_range(0, 3) == 0) s.py = 24'hFFFFFF - 24'($urandom_range(0, 4095));
        if ($urandom_range(0, 5) == 0) s.angle = 12'($urandom_range(0, 3) * 1024);
        pending_words.push_back(s);
        steps = $urandom_range(0, 30);
        for (int i = 0; i < steps; i++) pending_words.push_back(rand_word(rgd_pkg::ACT_STEP));
        pending_words.push_back(rand_word(rgd_pkg::ACT_FINISH));
        total += steps + 2;
      end
    end
    repeat (6) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    wait (pending_words.size() < 150);
    calm = 1'b1;
    wait (pending_words.size() == 0 && !in_valid);
    wait (expected_cells.size() == 0);
    repeat (200) @(posedge clk);
    if (fail_count == 0 && expected_cells.size() == 0)
      $display("** ray_grid_dda_traversal: PASSED **");
    else
      $display("** ray_grid_dda_traversal: FAILED **");
    $finish;
  end
endmodule
`default_nettype wire

[filelist.f]
hdl/rgd_pkg.sv
hdl/rgd_ctrl.sv
hdl/rgd_datapath.sv
hdl/ray_grid_dda_traversal.sv
bench/ray_grid_dda_traversal_tb.sv
